// ===== rtl/srctl_pkg.sv =====
// Package for the servo ramp controller: FSM state type, register indexes,
// per-channel state word, divider request/response types and fixed constants.
// No dependencies.
package srctl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DEGREES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX     = 3'd5;

    localparam logic CMD_SET     = 1'b0;
    localparam logic CMD_SERVICE = 1'b1;

    localparam logic [7:0]  ANGLE_RESET      = 8'd90;
    localparam logic [7:0]  ANGLE_FULL       = 8'd180;
    localparam logic [7:0]  ANGLE_MIN_RESET  = 8'd0;
    localparam logic [7:0]  ANGLE_MAX_RESET  = 8'd180;
    localparam logic [7:0]  STEP_DEG_RESET   = 8'd5;
    localparam logic [15:0] INTERVAL_RESET   = 16'd20;
    localparam logic [11:0] PULSE_MIN_RESET  = 12'd150;
    localparam logic [11:0] PULSE_MAX_RESET  = 12'd600;

    // step count divide: 8-bit angle difference by 8-bit step size
    localparam int DVD_W = 8;
    localparam int DVS_W = 8;

    // |angle * pulse span| < 2^20; x / 180 = ((x >> 2) * RECIP_45) >> RECIP_SHIFT
    localparam int          MAG_W       = 21;
    localparam logic [18:0] RECIP_45    = 19'd372828;
    localparam int          RECIP_SHIFT = 24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_MAP,
        S_EMIT_WR_HOLD
    } state_t;

    typedef struct packed {
        logic [7:0]  cur;
        logic [7:0]  goal;
        logic        down;
        logic [7:0]  steps;
        logic        moving;
        logic [31:0] last_time;
    } chan_state_t;

    localparam chan_state_t CHAN_RESET = '{
        cur:       ANGLE_RESET,
        goal:      ANGLE_RESET,
        down:      1'b0,
        steps:     8'd0,
        moving:    1'b0,
        last_time: 32'd0
    };

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/srctl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srctl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/srctl_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on srctl_pkg (request/response types and widths).
module srctl_div (
    input  logic                clk,
    input  logic                rst_n,
    input  srctl_pkg::div_req_t req,
    output srctl_pkg::div_rsp_t rsp
);

    import srctl_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    busy_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    start_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg && cnt_reg == '0)
        else $error("divider start did not arm the iteration count");

    done_after_full_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg) && $past(cnt_reg) == CNT_W'(DVD_W - 1))
        else $error("divider finished without a full run");

endmodule

// ===== rtl/servo_ramp_controller.sv =====
// Servo ramp controller, top level. One item in flight; input stalls until it retires.
// Set target: state read, step divide, state write; then the next beat is accepted.
// Service, due: read, multiply, scale, map, emit; the last step adds a final result
// the same way. Not due or idle: back to idle. A stalled result holds the emit state.
// Reset: registers to defaults, per-channel valid bits cleared so every channel
// reads 90 degrees and idle; no clearing pass.
module servo_ramp_controller #(
    parameter int CHANNELS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [srctl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srctl_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 command,
    input  logic [3:0]                           channel,
    input  logic [7:0]                           target_angle,
    input  logic [31:0]                          time_ms,

    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [3:0]                           pwm_channel,
    output logic [11:0]                          pulse_width,
    output logic                                 move_done,
    output logic                                 last
);

    import srctl_pkg::*;

    localparam int AW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

    state_t state_reg, state_next;

    logic [7:0]  angle_min_reg, angle_max_reg, step_deg_reg;
    logic [15:0] interval_reg;
    logic [11:0] pulse_min_reg, pulse_max_reg;

    logic        cmd_reg;
    logic [3:0]  chan_reg;
    logic [7:0]  tgt_reg;
    logic [31:0] time_reg;

    logic [CHANNELS-1:0] valid_reg;
    logic                hit_reg;
    chan_state_t         st_reg, st_next, ld;
    logic                second_reg, second_next;
    logic [7:0]          angle_reg, angle_next;
    logic signed [21:0]  prod_reg, prod_next;
    logic [35:0]         scale_reg, scale_next;
    logic [11:0]         pulse_reg, pulse_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_chan_reg;
    logic [11:0] out_pulse_reg;
    logic        out_done_reg, out_done_next;
    logic        out_last_reg, out_last_next;
    logic        out_load;

    logic [AW-1:0]          addr;
    logic                   chan_ok;
    logic                   ram_we;
    logic [$bits(chan_state_t)-1:0] ram_rdata;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic [7:0]         goal_c, diff_c, step_c, stepped_c, a_c;
    logic [8:0]         sum_c;
    logic [31:0]        elapsed_c;
    logic signed [12:0] span_c;
    logic [MAG_W-1:0]   mag_c;
    logic [11:0]        q_c;

    assign cfg_ready  = 1'b1;
    assign item_stall = state_reg != S_IDLE;
    assign addr       = AW'(chan_reg);
    assign chan_ok    = {3'b000, chan_reg} < 7'(CHANNELS);
    assign ld         = hit_reg ? chan_state_t'(ram_rdata) : CHAN_RESET;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_min_reg <= ANGLE_MIN_RESET;
            angle_max_reg <= ANGLE_MAX_RESET;
            step_deg_reg  <= STEP_DEG_RESET;
            interval_reg  <= INTERVAL_RESET;
            pulse_min_reg <= PULSE_MIN_RESET;
            pulse_max_reg <= PULSE_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ANGLE_MIN:     angle_min_reg <= cfg_data[7:0];
                CFG_ANGLE_MAX:     angle_max_reg <= cfg_data[7:0];
                CFG_STEP_DEGREES:  step_deg_reg  <= cfg_data[7:0];
                CFG_STEP_INTERVAL: interval_reg  <= cfg_data;
                CFG_PULSE_MIN:     pulse_min_reg <= cfg_data[11:0];
                CFG_PULSE_MAX:     pulse_max_reg <= cfg_data[11:0];
                default:           ;
            endcase
        end
    end

    // datapath helpers
    always_comb
    begin
        if (tgt_reg < angle_min_reg)
        begin
            goal_c = angle_min_reg;
        end
        else if (tgt_reg > angle_max_reg)
        begin
            goal_c = angle_max_reg;
        end
        else
        begin
            goal_c = tgt_reg;
        end
        diff_c    = goal_c > ld.cur ? goal_c - ld.cur : ld.cur - goal_c;
        elapsed_c = time_reg - ld.last_time;
        step_c    = step_deg_reg == 8'd0 ? 8'd1 : step_deg_reg;
        sum_c     = {1'b0, st_reg.cur} + {1'b0, step_c};
        if (st_reg.down)
        begin
            stepped_c = st_reg.cur >= step_c ? st_reg.cur - step_c : 8'd0;
        end
        else
        begin
            stepped_c = sum_c[8] ? 8'hFF : sum_c[7:0];
        end
        a_c    = angle_reg > ANGLE_FULL ? ANGLE_FULL : angle_reg;
        span_c = $signed({1'b0, pulse_max_reg}) - $signed({1'b0, pulse_min_reg});
        mag_c  = prod_reg[21] ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);
        q_c    = scale_reg[RECIP_SHIFT +: 12];
    end

    assign out_load = !out_valid_reg || !result_stall;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        st_next          = st_reg;
        second_next      = second_reg;
        angle_next       = angle_reg;
        prod_next        = prod_reg;
        scale_next       = scale_reg;
        pulse_next       = pulse_reg;
        out_valid_next   = out_valid_reg && result_stall;
        out_done_next    = out_done_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(diff_c);
        div_req.divisor  = step_c;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = chan_ok ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                st_next = ld;
                if (cmd_reg == CMD_SET)
                begin
                    st_next.goal      = goal_c;
                    st_next.down      = !(goal_c > ld.cur);
                    st_next.last_time = time_reg;
                    div_req.start     = 1'b1;
                    state_next        = S_DIV;
                end
                else if (!ld.moving || ld.steps == 8'd0 ||
                         elapsed_c < {16'd0, interval_reg})
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    angle_next  = ld.cur;
                    second_next = 1'b0;
                    state_next  = S_MUL;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    st_next.steps  = div_rsp.quotient;
                    st_next.moving = div_rsp.quotient != 8'd0;
                    ram_we         = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MUL:
            begin
                prod_next  = $signed({1'b0, a_c}) * span_c;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                scale_next = {17'd0, mag_c[MAG_W-1:2]} * {17'd0, RECIP_45};
                state_next = S_MAP;
            end
            S_MAP:
            begin
                pulse_next = prod_reg[21] ? pulse_min_reg - q_c : pulse_min_reg + q_c;
                state_next = S_EMIT_WR_HOLD;
            end
            S_EMIT_WR_HOLD:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (!second_reg)
                    begin
                        out_done_next     = 1'b0;
                        out_last_next     = st_reg.steps != 8'd1;
                        st_next.cur       = stepped_c;
                        st_next.steps     = st_reg.steps - 8'd1;
                        st_next.last_time = time_reg;
                        if (st_reg.steps == 8'd1)
                        begin
                            st_next.moving = 1'b0;
                            second_next    = 1'b1;
                            angle_next     = st_reg.goal;
                            state_next     = S_MUL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        out_done_next = 1'b1;
                        out_last_next = 1'b1;
                        st_next.cur   = st_reg.goal;
                        st_next.down  = 1'b0;
                        ram_we        = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
            if (ram_we)
            begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            cmd_reg  <= command;
            chan_reg <= channel;
            tgt_reg  <= target_angle;
            time_reg <= time_ms;
        end
        if (state_reg == S_RD)
        begin
            hit_reg <= valid_reg[addr];
        end
        st_reg       <= st_next;
        angle_reg    <= angle_next;
        prod_reg     <= prod_next;
        scale_reg    <= scale_next;
        pulse_reg    <= pulse_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
        if (state_reg == S_EMIT_WR_HOLD && out_load)
        begin
            out_chan_reg  <= chan_reg;
            out_pulse_reg <= pulse_reg;
        end
    end

    srctl_ram #(
        .WIDTH ($bits(chan_state_t)),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (st_next),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    srctl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign result_valid = out_valid_reg;
    assign pwm_channel  = out_chan_reg;
    assign pulse_width  = out_pulse_reg;
    assign move_done    = out_done_reg;
    assign last         = out_last_reg;

    write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> chan_ok)
        else $error("state write for a channel out of range");

    div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider result with nobody waiting");

    done_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && move_done |-> last)
        else $error("final ramp beat not marked last");

    first_of_two_rescales: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_WR_HOLD && out_load && !second_reg && st_reg.steps == 8'd1
        |=> state_reg == S_MUL && second_reg)
        else $error("ramp end did not schedule the final beat");

endmodule
